/* sv/csd_pkg.sv */
// ----------------------------------------------------------------------------
// CSD recoder package
// Shared widths, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package csd_pkg;

   localparam int VALUE_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int MASK_W    = 32;
   localparam int POS_W     = 5;
   localparam int CNT_W     = 5;
   localparam int NZ_W      = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAC_PLACES    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NONZERO_BUDGET = 2'd2;

   localparam logic [POS_W-1:0] RESET_FRAC_PLACES    = 5'd16;
   localparam logic [NZ_W-1:0]  RESET_NONZERO_BUDGET = 6'd32;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

endpackage

/* sv/csd_if.sv */
// ----------------------------------------------------------------------------
// CSD recoder channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface csd_req_if;
   logic                      valid;
   logic                      ready;
   logic signed [31:0]        value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface csd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] plus_mask;
   logic [31:0] minus_mask;
   logic [4:0]  int_digits;
   logic [4:0]  frac_digits;
   logic [5:0]  nonzero_count;

   modport source (output valid, output plus_mask, output minus_mask, output int_digits,
                   output frac_digits, output nonzero_count, input ready);
   modport sink   (input valid, input plus_mask, input minus_mask, input int_digits,
                   input frac_digits, input nonzero_count, output ready);
endinterface

/* sv/csd_recoder_fixed_point_top.sv */
// ----------------------------------------------------------------------------
// CSD recoder top level
// Recodes one signed Q16.16 value into canonical signed digit masks.
// ----------------------------------------------------------------------------
// After the transfer in, the block walks the digit positions from bit 31 down
// to the lowest kept one, stopping sooner for a zero input or an early budget
// stop, and then registers the result; a stalled response adds its wait.
// Synchronous reset returns the controller to idle, drops the result valid
// and restores the configuration registers to their default values.
module csd_recoder_fixed_point_top (
   input  logic                              clock,
   input  logic                              reset,
   csd_req_if.sink                           req_ch,
   csd_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [csd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import csd_pkg::*;

   cmd_type    cmd;
   status_type status;

   csd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   csd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .in_value          (req_ch.value),
      .cmd               (cmd),
      .status            (status),
      .out_plus_mask     (rsp_ch.plus_mask),
      .out_minus_mask    (rsp_ch.minus_mask),
      .out_int_digits    (rsp_ch.int_digits),
      .out_frac_digits   (rsp_ch.frac_digits),
      .out_nonzero_count (rsp_ch.nonzero_count)
   );

endmodule

/* sv/csd_ctrl.sv */
// ----------------------------------------------------------------------------
// CSD recoder controller
// Sequences load, digit steps and result transfer for one item at a time.
// ----------------------------------------------------------------------------
module csd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   input  csd_pkg::status_type status,
   output csd_pkg::cmd_type    cmd
);
   import csd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_STEP   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || out_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

/* sv/csd_dp.sv */
// ----------------------------------------------------------------------------
// CSD recoder datapath
// Configuration registers, remainder, digit select and result registers.
// ----------------------------------------------------------------------------
module csd_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [csd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic signed [csd_pkg::VALUE_W-1:0]   in_value,
   input  csd_pkg::cmd_type                     cmd,
   output csd_pkg::status_type                  status,
   output logic [csd_pkg::MASK_W-1:0]           out_plus_mask,
   output logic [csd_pkg::MASK_W-1:0]           out_minus_mask,
   output logic [csd_pkg::CNT_W-1:0]            out_int_digits,
   output logic [csd_pkg::CNT_W-1:0]            out_frac_digits,
   output logic [csd_pkg::NZ_W-1:0]             out_nonzero_count
);
   import csd_pkg::*;

   logic                     limit_mode_ff;
   logic [POS_W-1:0]         frac_places_ff;
   logic [NZ_W-1:0]          nonzero_budget_ff;

   logic signed [VALUE_W:0]  r_ff, r_in;
   logic [POS_W-1:0]         k_ff, k_in;
   logic [NZ_W-1:0]          left_ff, left_in;
   logic                     started_ff, started_in;
   logic                     big_ff, big_in;
   logic                     zero_ff, zero_in;
   logic [MASK_W-1:0]        plus_ff, plus_in;
   logic [MASK_W-1:0]        minus_ff, minus_in;
   logic [CNT_W-1:0]         int_ff, int_in;
   logic [CNT_W-1:0]         frac_ff, frac_in;
   logic [NZ_W-1:0]          nz_ff, nz_in;

   logic [MASK_W-1:0]        rsp_plus_ff;
   logic [MASK_W-1:0]        rsp_minus_ff;
   logic [CNT_W-1:0]         rsp_int_ff;
   logic [CNT_W-1:0]         rsp_frac_ff;
   logic [NZ_W-1:0]          rsp_nz_ff;

   logic [POS_W-1:0]         places;
   logic [POS_W-1:0]         low;
   logic [NZ_W-1:0]          budget_init;
   logic [VALUE_W-1:0]       mag;
   logic signed [VALUE_W+2:0] r_ext;
   logic signed [VALUE_W+2:0] t;
   logic [VALUE_W+2:0]       tw;
   logic [VALUE_W:0]         w;
   logic                     gt;
   logic                     lt;
   logic                     active;
   logic                     brk;
   logic                     take;
   logic [NZ_W-1:0]          left_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_mode_ff     <= 1'b0;
         frac_places_ff    <= RESET_FRAC_PLACES;
         nonzero_budget_ff <= RESET_NONZERO_BUDGET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIMIT_MODE:     limit_mode_ff     <= csr_wdata[0];
            CSR_FRAC_PLACES:    frac_places_ff    <= csr_wdata[POS_W-1:0];
            CSR_NONZERO_BUDGET: nonzero_budget_ff <= csr_wdata[NZ_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      places      = (frac_places_ff > POS_W'(FRAC_BITS)) ? POS_W'(FRAC_BITS) : frac_places_ff;
      low         = limit_mode_ff ? '0 : POS_W'(FRAC_BITS) - places;
      budget_init = (nonzero_budget_ff == '0) ? NZ_W'(1) : nonzero_budget_ff;
      mag         = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;

      r_ext = (VALUE_W+3)'(r_ff);
      t     = (r_ext <<< 1) + r_ext;
      tw    = (VALUE_W+3)'(1) << ({1'b0, k_ff} + 6'd1);
      w     = (VALUE_W+1)'(1) << k_ff;
      gt    = t > $signed(tw);
      lt    = t < -$signed(tw);

      active = started_ff | (big_ff ? (gt | lt) : !k_ff[POS_W-1]);
      brk    = limit_mode_ff && !k_ff[POS_W-1] && ((left_ff == '0) || (r_ff == '0));
      take   = cmd.step && !zero_ff && active && !brk;
      left_dec = (left_ff != '0) ? left_ff - NZ_W'(1) : left_ff;

      status.last = zero_ff || brk || (k_ff == low);
   end

   always_comb begin
      r_in       = r_ff;
      k_in       = k_ff;
      left_in    = left_ff;
      started_in = started_ff;
      big_in     = big_ff;
      zero_in    = zero_ff;
      plus_in    = plus_ff;
      minus_in   = minus_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      nz_in      = nz_ff;
      if (cmd.load) begin
         r_in       = (VALUE_W+1)'(in_value);
         k_in       = POS_W'(VALUE_W - 1);
         left_in    = budget_init;
         started_in = 1'b0;
         big_in     = |mag[VALUE_W-1:FRAC_BITS];
         zero_in    = (in_value == '0);
         plus_in    = '0;
         minus_in   = '0;
         int_in     = '0;
         frac_in    = '0;
         nz_in      = '0;
      end else if (cmd.step) begin
         k_in = k_ff - POS_W'(1);
         if (take) begin
            if (!started_ff) begin
               started_in = 1'b1;
               int_in     = big_ff ? (k_ff - POS_W'(FRAC_BITS - 1)) : '0;
            end
            if (gt) begin
               plus_in[k_ff] = 1'b1;
               r_in          = r_ff - $signed(w);
               nz_in         = nz_ff + NZ_W'(1);
               left_in       = left_dec;
            end else if (lt) begin
               minus_in[k_ff] = 1'b1;
               r_in           = r_ff + $signed(w);
               nz_in          = nz_ff + NZ_W'(1);
               left_in        = left_dec;
            end
            if (!k_ff[POS_W-1]) begin
               frac_in = frac_ff + CNT_W'(1);
            end
            if (limit_mode_ff && (left_in == '0)) begin
               r_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff       <= r_in;
      k_ff       <= k_in;
      left_ff    <= left_in;
      started_ff <= started_in;
      big_ff     <= big_in;
      zero_ff    <= zero_in;
      plus_ff    <= plus_in;
      minus_ff   <= minus_in;
      int_ff     <= int_in;
      frac_ff    <= frac_in;
      nz_ff      <= nz_in;
      if (cmd.emit) begin
         rsp_plus_ff  <= plus_ff;
         rsp_minus_ff <= minus_ff;
         rsp_int_ff   <= int_ff;
         rsp_frac_ff  <= frac_ff;
         rsp_nz_ff    <= nz_ff;
      end
   end

   assign out_plus_mask     = rsp_plus_ff;
   assign out_minus_mask    = rsp_minus_ff;
   assign out_int_digits    = rsp_int_ff;
   assign out_frac_digits   = rsp_frac_ff;
   assign out_nonzero_count = rsp_nz_ff;

endmodule

/* sv/csd_checker.sv */
// ----------------------------------------------------------------------------
// CSD recoder checker
// Port-level properties of the recoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
module csd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] plus_mask,
   input logic [31:0] minus_mask,
   input logic [4:0]  int_digits,
   input logic [4:0]  frac_digits,
   input logic [5:0]  nonzero_count
);

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while an item is in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(plus_mask) && $stable(minus_mask)))
      else $error("stalled response changed");

   a_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((plus_mask & minus_mask) == 32'd0))
      else $error("digit both plus and minus");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($countones(plus_mask) + $countones(minus_mask)) == int'(nonzero_count)))
      else $error("nonzero count does not match masks");

   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((int_digits <= 5'd16) && (frac_digits <= 5'd16)))
      else $error("digit position count out of range");

endmodule

bind csd_recoder_fixed_point_top csd_checker u_csd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .plus_mask     (rsp_ch.plus_mask),
   .minus_mask    (rsp_ch.minus_mask),
   .int_digits    (rsp_ch.int_digits),
   .frac_digits   (rsp_ch.frac_digits),
   .nonzero_count (rsp_ch.nonzero_count)
);

/* tb/csd_recoder_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSD recoder result checker
// Watches the request, response and register ports, predicts the digit masks
// and counts for every accepted request, and compares each response with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module csd_recoder_checker (
   input  logic                            clock,
   input  logic                            reset,
   csd_req_if                              req_ch,
   csd_rsp_if                              rsp_ch,
   input  logic                            csr_we,
   input  logic [csd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [csd_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              outstanding
);
   import csd_pkg::*;

   typedef struct packed {
      logic [MASK_W-1:0] plus_mask;
      logic [MASK_W-1:0] minus_mask;
      logic [POS_W-1:0]  int_digits;
      logic [CNT_W-1:0]  frac_digits;
      logic [NZ_W-1:0]   nonzero_count;
   } csd_digits_type;

   logic              budget_mode_q    = 1'b0;
   logic [POS_W-1:0]  frac_places_q    = RESET_FRAC_PLACES;
   logic [NZ_W-1:0]   nonzero_budget_q = RESET_NONZERO_BUDGET;
   csd_digits_type    expected_digits[$];
   int                mismatches = 0;
   int                queued     = 0;

   assign error_count = mismatches;
   assign outstanding = queued;

   function automatic csd_digits_type recode_csd(input logic signed [VALUE_W-1:0] value);
      csd_digits_type digits;
      longint      mag;
      longint      rem;
      longint      weight;
      int          top;
      int          low;
      int          m;
      int          places;
      int          left;
      int          frac_count;
      int          nz_count;
      digits     = '0;
      frac_count = 0;
      nz_count   = 0;
      mag = (value < 0) ? -longint'(value) : longint'(value);
      if (mag != 0) begin
         rem    = longint'(value);
         left   = (nonzero_budget_q == 0) ? 1 : int'(nonzero_budget_q);
         places = (frac_places_q > FRAC_BITS) ? FRAC_BITS : int'(frac_places_q);
         if (mag >= (longint'(1) << FRAC_BITS)) begin
            m = 0;
            while (m < 63 && (longint'(1) << m) < 3 * mag) m++;
            digits.int_digits = POS_W'(m - 1 - FRAC_BITS);
            top = m - 2;
         end else begin
            top = FRAC_BITS - 1;
         end
         low = budget_mode_q ? 0 : FRAC_BITS - places;
         for (int k = top; k >= low; k--) begin
            if (budget_mode_q && k < FRAC_BITS && (left == 0 || rem == 0)) break;
            weight = longint'(1) << k;
            if (3 * rem > 2 * weight) begin
               digits.plus_mask[k] = 1'b1;
               rem -= weight;
               nz_count++;
               if (left != 0) left--;
            end else if (3 * rem < -2 * weight) begin
               digits.minus_mask[k] = 1'b1;
               rem += weight;
               nz_count++;
               if (left != 0) left--;
            end
            if (k < FRAC_BITS) frac_count++;
            if (budget_mode_q && left == 0) rem = 0;
         end
      end
      digits.frac_digits   = CNT_W'(frac_count);
      digits.nonzero_count = NZ_W'(nz_count);
      return digits;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      csd_digits_type head;
      if (reset) begin
         budget_mode_q    = 1'b0;
         frac_places_q    = RESET_FRAC_PLACES;
         nonzero_budget_q = RESET_NONZERO_BUDGET;
         expected_digits.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual plus %0h minus %0h",
                        $time, rsp_ch.plus_mask, rsp_ch.minus_mask);
               mismatches++;
            end else begin
               head = expected_digits.pop_front();
               check_field("plus_mask", head.plus_mask, rsp_ch.plus_mask);
               check_field("minus_mask", head.minus_mask, rsp_ch.minus_mask);
               check_field("int_digits", 32'(head.int_digits), 32'(rsp_ch.int_digits));
               check_field("frac_digits", 32'(head.frac_digits), 32'(rsp_ch.frac_digits));
               check_field("nonzero_count", 32'(head.nonzero_count),
                           32'(rsp_ch.nonzero_count));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            expected_digits.push_back(recode_csd(req_ch.value));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_LIMIT_MODE:     budget_mode_q    = csr_wdata[0];
               CSR_FRAC_PLACES:    frac_places_q    = csr_wdata[POS_W-1:0];
               CSR_NONZERO_BUDGET: nonzero_budget_q = csr_wdata[NZ_W-1:0];
               default: ;
            endcase
         end
      end
      queued <= expected_digits.size();
   end

endmodule

/* tb/tb_csd_recoder_fixed_point_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CSD recoder testbench
// Sends directed edge values and then random values through the recoder under
// a series of register settings in both limit modes, with random gaps on the
// request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_csd_recoder_fixed_point_top;
   import csd_pkg::*;

   localparam int   NUM_SETTINGS      = 12;
   localparam int   ITEMS_PER_SETTING = 84;
   localparam int   NUM_DIRECTED      = 17;
   localparam int   SETTLE_CYCLES     = 40;
   localparam logic MODE_PLACES       = 1'b0;
   localparam logic MODE_BUDGET       = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    sender_idle_pct;
   int                    receiver_idle_pct;
   int                    error_count;
   int                    outstanding;

   logic setting_mode [NUM_SETTINGS] = '{MODE_PLACES, MODE_PLACES, MODE_PLACES, MODE_PLACES,
                                         MODE_BUDGET, MODE_BUDGET, MODE_BUDGET, MODE_BUDGET,
                                         MODE_BUDGET, MODE_BUDGET, MODE_PLACES, MODE_PLACES};
   int   setting_places [NUM_SETTINGS] = '{16, 0, 8, 31, 16, 0, 4, 17, 16, 2, 1, 15};
   int   setting_budget [NUM_SETTINGS] = '{32, 1, 5, 0, 1, 0, 3, 63, 32, 8, 17, 2};
   logic [31:0] directed_values [NUM_DIRECTED] = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h0001_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'h0001_8000, 32'h0000_AAAA,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'h0003_0000, 32'hFFFD_0000,
      32'h0000_5555, 32'h7FFF_0000};

   csd_req_if req_if();
   csd_rsp_if rsp_if();

   csd_recoder_fixed_point_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   csd_recoder_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      case ($urandom_range(5))
         0: v = $urandom();
         1: v = $urandom_range(32'hFFFF);
         2: v = $urandom() << 16;
         3: begin
            v = '0;
            repeat ($urandom_range(1, 4)) v ^= 32'h1 << $urandom_range(31);
         end
         4: v = ((32'h1 << $urandom_range(31)) / 32'd3) + 32'($urandom_range(2)) - 32'd1;
         default: v = $urandom() >> $urandom_range(31);
      endcase
      if ($urandom_range(1) == 1) v = -v;
      return v;
   endfunction

   task automatic send_value(input logic [31:0] v);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic mode, input int places, input int budget);
      csr_we    <= 1'b1;
      csr_index <= CSR_LIMIT_MODE;
      csr_wdata <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_index <= CSR_FRAC_PLACES;
      csr_wdata <= CSR_DATA_W'(places);
      @(posedge clock);
      csr_index <= CSR_NONZERO_BUDGET;
      csr_wdata <= CSR_DATA_W'(budget);
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.value      = '0;
      rsp_if.ready      = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_LIMIT_MODE;
      csr_wdata         = '0;
      sender_idle_pct   = 12;
      receiver_idle_pct = 74;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_values[i]) send_value(directed_values[i]);
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain();
         if (s == NUM_SETTINGS / 3) begin
            sender_idle_pct   = 74;
            receiver_idle_pct = 12;
         end else if (s == 2 * NUM_SETTINGS / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         write_settings(setting_mode[s], setting_places[s], setting_budget[s]);
         repeat (ITEMS_PER_SETTING) send_value(random_value());
      end
      drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* sim.f */
sv/csd_pkg.sv
sv/csd_if.sv
sv/csd_ctrl.sv
sv/csd_dp.sv
sv/csd_recoder_fixed_point_top.sv
sv/csd_checker.sv
tb/csd_recoder_checker.sv
tb/tb_csd_recoder_fixed_point_top.sv
